// ===== sv/pfc_pkg.sv =====
// shared types, constants and helper functions of the playfair cipher block
// no dependencies; used by pfc_ctrl, pfc_dpath and playfair_digraph_cipher_top
package pfc_pkg;

  localparam int GRID_SIDE  = 5;
  localparam int GRID_CELLS = 25;
  localparam int ALPHA      = 26;

  localparam logic [4:0] LTR_I    = 5'd8;
  localparam logic [4:0] LTR_J    = 5'd9;
  localparam logic [4:0] LTR_X    = 5'd23;
  localparam logic [4:0] LTR_LAST = 5'(ALPHA - 1);
  localparam logic [4:0] CELLS_N  = 5'(GRID_CELLS);
  localparam logic [2:0] SIDE_MAX = 3'(GRID_SIDE - 1);

  localparam logic [7:0] CHAR_A     = 8'd97;
  localparam logic [7:0] CHAR_Z     = 8'd122;
  localparam logic [7:0] CHAR_UA    = 8'd65;
  localparam logic [7:0] CHAR_UZ    = 8'd90;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CASE_OFS   = 8'd32;

  typedef enum logic [1:0] {
    REQ_KEY      = 2'd0,
    REQ_KEY_DONE = 2'd1,
    REQ_MSG      = 2'd2,
    REQ_MSG_END  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONLETTER = 2'd1,
    ST_ORDER     = 2'd2
  } status_t;

  typedef struct packed {
    logic       space;
    logic       letter;
    logic [4:0] idx;
  } chr_t;

  typedef struct packed {
    logic    place_key;
    logic    fill_start;
    logic    fill_step;
    logic    ready_set;
    logic    pend_load;
    logic    pend_clear;
    logic    pos_rd;
    logic    q_is_x;
    logic    grid_rd;
    logic    out_load_pair;
    logic    out_load_flag;
    status_t flag_code;
  } cmd_t;

  typedef struct packed {
    logic grid_ready;
    logic pend_valid;
    logic pend_match;
    logic ch_space;
    logic ch_letter;
    logic fill_done;
    logic out_busy;
  } sts_t;

  function automatic chr_t clean_char(logic [7:0] ch);
    chr_t       r;
    logic [7:0] c;
    logic [7:0] d;
    r = '0;
    c = ch;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      c = c + CASE_OFS;
    end
    d = c - CHAR_A;
    if (ch == CHAR_SPACE) begin
      r.space = 1'b1;
    end else if (c >= CHAR_A && c <= CHAR_Z) begin
      r.letter = 1'b1;
      r.idx    = (d[4:0] == LTR_J) ? LTR_I : d[4:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] cell_row(logic [4:0] c);
    logic [2:0] r;
    if (c >= 5'd20) begin
      r = 3'd4;
    end else if (c >= 5'd15) begin
      r = 3'd3;
    end else if (c >= 5'd10) begin
      r = 3'd2;
    end else if (c >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [4:0] row_base(logic [2:0] r);
    return ({2'b00, r} << 2) + {2'b00, r};
  endfunction

  function automatic logic [2:0] cell_col(logic [4:0] c);
    logic [4:0] d;
    d = c - row_base(cell_row(c));
    return d[2:0];
  endfunction

  function automatic logic [2:0] step_idx(logic [2:0] v, logic back);
    logic [2:0] r;
    if (back) begin
      r = (v == 3'd0) ? SIDE_MAX : v - 3'd1;
    end else begin
      r = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== sv/pfc_ctrl.sv =====
// controller state machine of the playfair cipher block
// depends on pfc_pkg; drives commands into pfc_dpath
module pfc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_req_type,
  output logic           in_stall,
  input  pfc_pkg::sts_t  sts,
  output pfc_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_POS,
    S_GRID
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  pfc_pkg::req_t req;

  assign req      = pfc_pkg::req_t'(in_req_type);
  assign in_stall = (state_r != S_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (req)
            pfc_pkg::REQ_KEY, pfc_pkg::REQ_KEY_DONE: begin
              if (sts.grid_ready) begin
                cmd.out_load_flag = 1'b1;
                cmd.flag_code     = pfc_pkg::ST_ORDER;
              end else if (req == pfc_pkg::REQ_KEY_DONE) begin
                cmd.fill_start = 1'b1;
                state_nxt      = S_FILL;
              end else if (sts.ch_letter) begin
                cmd.place_key = 1'b1;
              end else if (!sts.ch_space) begin
                cmd.out_load_flag = 1'b1;
                cmd.flag_code     = pfc_pkg::ST_NONLETTER;
              end
            end
            pfc_pkg::REQ_MSG: begin
              if (!sts.grid_ready) begin
                cmd.out_load_flag = 1'b1;
                cmd.flag_code     = pfc_pkg::ST_ORDER;
              end else if (sts.ch_letter) begin
                if (!sts.pend_valid) begin
                  cmd.pend_load = 1'b1;
                end else if (sts.pend_match) begin
                  cmd.pos_rd    = 1'b1;
                  cmd.q_is_x    = 1'b1;
                  cmd.pend_load = 1'b1;
                  state_nxt     = S_POS;
                end else begin
                  cmd.pos_rd     = 1'b1;
                  cmd.pend_clear = 1'b1;
                  state_nxt      = S_POS;
                end
              end else if (!sts.ch_space) begin
                cmd.out_load_flag = 1'b1;
                cmd.flag_code     = pfc_pkg::ST_NONLETTER;
              end
            end
            pfc_pkg::REQ_MSG_END: begin
              if (!sts.grid_ready) begin
                cmd.out_load_flag = 1'b1;
                cmd.flag_code     = pfc_pkg::ST_ORDER;
              end else if (sts.pend_valid) begin
                cmd.pos_rd     = 1'b1;
                cmd.q_is_x     = 1'b1;
                cmd.pend_clear = 1'b1;
                state_nxt      = S_POS;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          cmd.ready_set = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_POS: begin
        cmd.grid_rd = 1'b1;
        state_nxt   = S_GRID;
      end
      S_GRID: begin
        if (!sts.out_busy) begin
          cmd.out_load_pair = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while a request is in progress");

  a_pos_then_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pos_rd |=> cmd.grid_rd)
    else $error("position lookup not followed by grid lookup");

endmodule

// ===== sv/pfc_dpath.sv =====
// datapath of the playfair cipher block: grid stores, pairing, lookups, output
// depends on pfc_pkg; commanded by pfc_ctrl
module pfc_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic [7:0]     in_char_in,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_first_char,
  output logic [7:0]     out_second_char,
  output logic [1:0]     out_status,
  input  pfc_pkg::cmd_t  cmd,
  output pfc_pkg::sts_t  sts
);

  logic [4:0] grid_mem [pfc_pkg::GRID_CELLS];
  logic [4:0] pos_mem  [pfc_pkg::ALPHA];

  logic                         mode_r;
  logic [pfc_pkg::ALPHA-1:0]    used_r, used_nxt;
  logic [4:0]                   fill_cnt_r, fill_cnt_nxt;
  logic [4:0]                   fill_ltr_r, fill_ltr_nxt;
  logic                         ready_r, ready_nxt;
  logic [4:0]                   pend_r, pend_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [4:0]                   pos_a_r, pos_b_r;
  logic [4:0]                   grid_a_r, grid_b_r;
  logic [7:0]                   first_r, second_r;
  logic [1:0]                   status_r;

  pfc_pkg::chr_t chr;
  logic [4:0]    place_ltr;
  logic          place_ok;
  logic [4:0]    q_ltr;
  logic [2:0]    r1, c1, r2, c2;
  logic [2:0]    nr1, nc1, nr2, nc2;
  logic [4:0]    cell_a, cell_b;

  assign chr = pfc_pkg::clean_char(in_char_in);

  assign place_ltr = cmd.fill_step ? fill_ltr_r : chr.idx;
  assign place_ok  = (cmd.place_key || (cmd.fill_step && fill_ltr_r != pfc_pkg::LTR_J))
                     && !used_r[place_ltr] && (fill_cnt_r < pfc_pkg::CELLS_N);
  assign q_ltr     = cmd.q_is_x ? pfc_pkg::LTR_X : chr.idx;

  // row, column or rectangle rule on the looked-up cells
  always_comb begin
    r1  = pfc_pkg::cell_row(pos_a_r);
    c1  = pfc_pkg::cell_col(pos_a_r);
    r2  = pfc_pkg::cell_row(pos_b_r);
    c2  = pfc_pkg::cell_col(pos_b_r);
    nr1 = r1;
    nc1 = c1;
    nr2 = r2;
    nc2 = c2;
    if (r1 == r2) begin
      nc1 = pfc_pkg::step_idx(c1, mode_r);
      nc2 = pfc_pkg::step_idx(c2, mode_r);
    end else if (c1 == c2) begin
      nr1 = pfc_pkg::step_idx(r1, mode_r);
      nr2 = pfc_pkg::step_idx(r2, mode_r);
    end else begin
      nc1 = c2;
      nc2 = c1;
    end
    cell_a = pfc_pkg::row_base(nr1) + {2'b00, nc1};
    cell_b = pfc_pkg::row_base(nr2) + {2'b00, nc2};
  end

  always_ff @(posedge clk) begin
    if (place_ok) begin
      grid_mem[fill_cnt_r] <= place_ltr;
      pos_mem[place_ltr]   <= fill_cnt_r;
    end
    if (cmd.pos_rd) begin
      pos_a_r <= pos_mem[pend_r];
      pos_b_r <= pos_mem[q_ltr];
    end
    if (cmd.grid_rd) begin
      grid_a_r <= grid_mem[cell_a];
      grid_b_r <= grid_mem[cell_b];
    end
  end

  always_comb begin
    used_nxt     = used_r;
    fill_cnt_nxt = fill_cnt_r;
    fill_ltr_nxt = fill_ltr_r;
    ready_nxt    = ready_r || cmd.ready_set;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    if (place_ok) begin
      used_nxt[place_ltr] = 1'b1;
      fill_cnt_nxt        = fill_cnt_r + 5'd1;
    end
    if (cmd.fill_start) begin
      fill_ltr_nxt = '0;
    end else if (cmd.fill_step) begin
      fill_ltr_nxt = fill_ltr_r + 5'd1;
    end
    if (cmd.pend_load) begin
      pend_nxt   = chr.idx;
      pend_v_nxt = 1'b1;
    end else if (cmd.pend_clear) begin
      pend_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load_pair || cmd.out_load_flag) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      used_r      <= '0;
      fill_cnt_r  <= '0;
      fill_ltr_r  <= '0;
      ready_r     <= 1'b0;
      pend_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      used_r      <= used_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_ltr_r  <= fill_ltr_nxt;
      ready_r     <= ready_nxt;
      pend_r      <= pend_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load_pair) begin
      first_r  <= pfc_pkg::CHAR_A + {3'b000, grid_a_r};
      second_r <= pfc_pkg::CHAR_A + {3'b000, grid_b_r};
      status_r <= pfc_pkg::ST_OK;
    end else if (cmd.out_load_flag) begin
      first_r  <= '0;
      second_r <= '0;
      status_r <= cmd.flag_code;
    end
  end

  assign sts.grid_ready = ready_r;
  assign sts.pend_valid = pend_v_r;
  assign sts.pend_match = (chr.idx == pend_r);
  assign sts.ch_space   = chr.space;
  assign sts.ch_letter  = chr.letter;
  assign sts.fill_done  = (fill_ltr_r == pfc_pkg::LTR_LAST);
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid       = out_valid_r;
  assign out_first_char  = first_r;
  assign out_second_char = second_r;
  assign out_status      = status_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load_pair || cmd.out_load_flag) |-> !(out_valid_r && out_stall))
    else $error("output register loaded while its result waits");

  a_used_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_cnt_r))
    else $error("used letters disagree with fill count");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (fill_cnt_r == pfc_pkg::CELLS_N))
    else $error("grid ready with free cells");

endmodule

// ===== sv/playfair_digraph_cipher_top.sv =====
// top level of the playfair digraph cipher: controller plus datapath
// depends on pfc_pkg, pfc_ctrl and pfc_dpath
// output: flagged requests load the output register in the cycle after acceptance; a pair
// goes through position read and grid read, then the load, which waits while the output stalls
// throughput: 1 request per cycle while idle and the output is not stalled; a pair-forming
// request stalls the input until its pair is loaded, and key complete walks the 26 letters
// reset: synchronous active low; clears control, letter flags and mode, not the grid stores
module playfair_digraph_cipher_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_first_char,
  output logic [7:0] out_second_char,
  output logic [1:0] out_status
);

  pfc_pkg::cmd_t cmd;
  pfc_pkg::sts_t sts;

  pfc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  pfc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_first_char  (out_first_char),
    .out_second_char (out_second_char),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
